// File: sv/cts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cts_pkg
// Shared sizes, codes and state type of the cosine top-k search block.
// ----------------------------------------------------------------------------
package cts_pkg;

  localparam int ENTRIES  = 64;
  localparam int DIM      = 64;
  localparam int MAX_TOPK = 16;

  localparam int SLOT_W  = $clog2(ENTRIES);
  localparam int ELEM_W  = $clog2(DIM);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int N_W     = $clog2(DIM + 1);
  localparam int K_W     = $clog2(MAX_TOPK + 1);
  localparam int RANK_W  = $clog2(MAX_TOPK);
  localparam int ADDR_W  = SLOT_W + ELEM_W;

  // sum of squares, dot product, square root and divide widths
  localparam int SQ_W    = 31 + ELEM_W;
  localparam int DOT_W   = SQ_W + 1;
  localparam int RT_W    = (SQ_W + 1) / 2;
  localparam int BIT_TOP = (SQ_W - 1) & ~1;
  localparam int SQ_ITER = BIT_TOP / 2 + 1;
  localparam int DEN_W   = 2 * RT_W;
  localparam int DVD_W   = SQ_W + 15;
  localparam int ITER_W  = $clog2(DVD_W + 1);

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic {
    CFG_DIMS = 1'b0,
    CFG_TOPK = 1'b1
  } cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MAC,
    ST_SQRT,
    ST_MUL,
    ST_DIV,
    ST_INS,
    ST_EMIT
  } state_e;

endpackage

// File: sv/cosine_topk_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosine_topk_search
// Vector store with brute-force cosine scoring and a sorted top-k list.
// ----------------------------------------------------------------------------
// Store, remove and query elements: one request per cycle when not busy, no
// results. Last query element: per valid slot a MAC over the memory port,
// square roots, multiply, bit-serial divide and insert, then one result
// per cycle; busy holds off requests meanwhile. Results cannot be stalled.
// Reset clears valid bits and count, sets 64 dims, top-k 8; stores stay unset.
module cosine_topk_search (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             cmd_i,
  input  logic [cts_pkg::SLOT_W-1:0] slot_i,
  input  logic [cts_pkg::ELEM_W-1:0] elem_i,
  input  logic signed [15:0]     value_i,
  input  logic                   last_i,
  input  logic                   cfg_we_i,
  input  logic                   cfg_idx_i,
  input  logic [6:0]             cfg_data_i,
  output logic                   result_valid_o,
  output logic [cts_pkg::SLOT_W-1:0] result_slot_o,
  output logic signed [15:0]     score_o,
  output logic [cts_pkg::RANK_W-1:0] rank_o,
  output logic                   last_result_o,
  output logic [cts_pkg::CNT_W-1:0]  entry_count_o
);
  import cts_pkg::*;

  state_e state_q, state_d;

  logic [6:0]         dims_q;
  logic [4:0]         topk_q;
  logic [ENTRIES-1:0] valid_q;
  logic [CNT_W-1:0]   vcount_q;
  logic [N_W-1:0]     n_q;
  logic [K_W-1:0]     k_q;

  logic signed [15:0] vmem [ENTRIES*DIM];
  logic signed [15:0] qmem [DIM];
  logic signed [15:0] vrd_q, qrd_q;

  logic [CNT_W-1:0]   s_q;
  logic [N_W-1:0]     idx_q;
  logic               rd_v_q, pv_q;
  logic signed [31:0] pd_q;
  logic [30:0]        pa_q, pb_q;
  logic signed [DOT_W-1:0] dot_q;
  logic [SQ_W-1:0]    na_q, nb_q;

  logic [SQ_W-1:0]    xa_q, xb_q, bit_q;
  logic [SQ_W:0]      ra_q, rb_q;
  logic [ITER_W-1:0]  it_q;
  logic [DEN_W-1:0]   den_q;
  logic [DVD_W-1:0]   dvd_q, quo_q;
  logic [DEN_W:0]     rem_q;
  logic               neg_q, zero_q;

  logic [SLOT_W-1:0]  bslot_q [MAX_TOPK];
  logic signed [15:0] bscore_q [MAX_TOPK];
  logic [K_W-1:0]     cnt_q;
  logic [RANK_W-1:0]  e_q;

  logic               accept, issue, mac_done;
  logic [N_W-1:0]     n_new;
  logic [K_W-1:0]     k_new;
  logic [SQ_W:0]      ta, tb;
  logic [DEN_W:0]     rem_t;
  logic signed [15:0] sc;
  logic [MAX_TOPK-1:0] ge;
  logic               ins_ok;
  logic [SQ_W-1:0]    mag;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;
  assign issue  = (state_q == ST_MAC) && (idx_q < n_q);
  assign mac_done = (state_q == ST_MAC) && (idx_q == n_q) && !rd_v_q && !pv_q;

  always_comb begin
    n_new = (dims_q == 7'd0) ? N_W'(1) :
            (32'(dims_q) > DIM) ? N_W'(DIM) : N_W'(dims_q);
    k_new = (32'(topk_q) > MAX_TOPK) ? K_W'(MAX_TOPK) : K_W'(topk_q);
  end

  // square root steps, one bit pair per cycle; divide shift, dot magnitude
  assign ta    = ra_q + {1'b0, bit_q};
  assign tb    = rb_q + {1'b0, bit_q};
  assign rem_t = {rem_q[DEN_W-1:0], dvd_q[DVD_W-1]};
  assign mag   = dot_q[DOT_W-1] ? SQ_W'(-dot_q) : SQ_W'(dot_q);

  always_comb begin
    if (zero_q) begin
      sc = 16'sd0;
    end else if (!neg_q) begin
      sc = (quo_q > DVD_W'(32767)) ? 16'sd32767 : 16'(quo_q);
    end else begin
      sc = (quo_q > DVD_W'(32768)) ? -16'sd32768 : 16'(-quo_q);
    end
    for (int j = 0; j < MAX_TOPK; j++) begin
      ge[j] = (K_W'(j) < cnt_q) && (bscore_q[j] >= sc);
    end
    ins_ok = !ge[RANK_W'(k_q - K_W'(1))];
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (accept && cmd_i == CMD_WRITE) begin
      vmem[{slot_i, elem_i}] <= value_i;
    end
    vrd_q <= vmem[{s_q[SLOT_W-1:0], idx_q[ELEM_W-1:0]}];
  end

  always_ff @(posedge clk_i) begin
    if (accept && cmd_i == CMD_QUERY) begin
      qmem[elem_i] <= value_i;
    end
    qrd_q <= qmem[idx_q[ELEM_W-1:0]];
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && cmd_i == CMD_QUERY && last_i) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (s_q == CNT_W'(ENTRIES) || k_q == '0) begin
          state_d = (cnt_q == '0) ? ST_IDLE : ST_EMIT;
        end else if (valid_q[s_q[SLOT_W-1:0]]) begin
          state_d = ST_MAC;
        end
      end
      ST_MAC: begin
        if (mac_done) begin
          state_d = (na_q == '0 || nb_q == '0) ? ST_INS : ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (it_q == ITER_W'(SQ_ITER - 1)) state_d = ST_MUL;
      end
      ST_MUL:  state_d = ST_DIV;
      ST_DIV: begin
        if (it_q == ITER_W'(DVD_W - 1)) state_d = ST_INS;
      end
      ST_INS:  state_d = ST_SCAN;
      ST_EMIT: begin
        if (K_W'(e_q) == cnt_q - K_W'(1)) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      dims_q         <= 7'd64;
      topk_q         <= 5'd8;
      valid_q        <= '0;
      vcount_q       <= '0;
      rd_v_q         <= 1'b0;
      pv_q           <= 1'b0;
      cnt_q          <= '0;
      result_valid_o <= 1'b0;
    end else begin
      state_q        <= state_d;
      rd_v_q         <= issue;
      pv_q           <= rd_v_q;
      result_valid_o <= (state_q == ST_EMIT);
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_DIMS) dims_q <= cfg_data_i;
        else                       topk_q <= cfg_data_i[4:0];
      end
      if (accept) begin
        if (cmd_i == CMD_WRITE && last_i && !valid_q[slot_i]) begin
          valid_q[slot_i] <= 1'b1;
          vcount_q        <= vcount_q + CNT_W'(1);
        end else if (cmd_i == CMD_REMOVE && valid_q[slot_i]) begin
          valid_q[slot_i] <= 1'b0;
          vcount_q        <= vcount_q - CNT_W'(1);
        end
      end
      if (state_q == ST_IDLE) begin
        cnt_q <= '0;
      end else if (state_q == ST_INS && ins_ok && cnt_q < k_q) begin
        cnt_q <= cnt_q + K_W'(1);
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    pd_q <= qrd_q * vrd_q;
    pa_q <= 31'(qrd_q * qrd_q);
    pb_q <= 31'(vrd_q * vrd_q);
    unique case (state_q)
      ST_IDLE: begin
        n_q <= n_new;
        k_q <= k_new;
        s_q <= '0;
        e_q <= '0;
      end
      ST_SCAN: begin
        idx_q <= '0;
        dot_q <= '0;
        na_q  <= '0;
        nb_q  <= '0;
        if (!valid_q[s_q[SLOT_W-1:0]]) s_q <= s_q + CNT_W'(1);
      end
      ST_MAC: begin
        if (issue) idx_q <= idx_q + N_W'(1);
        if (pv_q) begin
          dot_q <= dot_q + DOT_W'(pd_q);
          na_q  <= na_q + SQ_W'(pa_q);
          nb_q  <= nb_q + SQ_W'(pb_q);
        end
        zero_q <= 1'b1;
        xa_q   <= na_q;
        xb_q   <= nb_q;
        ra_q   <= '0;
        rb_q   <= '0;
        bit_q  <= SQ_W'(1) << BIT_TOP;
        it_q   <= '0;
      end
      ST_SQRT: begin
        if ({1'b0, xa_q} >= ta) begin
          xa_q <= SQ_W'({1'b0, xa_q} - ta);
          ra_q <= (ra_q >> 1) + {1'b0, bit_q};
        end else begin
          ra_q <= ra_q >> 1;
        end
        if ({1'b0, xb_q} >= tb) begin
          xb_q <= SQ_W'({1'b0, xb_q} - tb);
          rb_q <= (rb_q >> 1) + {1'b0, bit_q};
        end else begin
          rb_q <= rb_q >> 1;
        end
        bit_q <= bit_q >> 2;
        it_q  <= it_q + ITER_W'(1);
      end
      ST_MUL: begin
        den_q  <= RT_W'(ra_q) * RT_W'(rb_q);
        dvd_q  <= {mag, 15'd0};
        rem_q  <= '0;
        quo_q  <= '0;
        neg_q  <= dot_q[DOT_W-1];
        zero_q <= 1'b0;
        it_q   <= '0;
      end
      ST_DIV: begin
        if (rem_t >= {1'b0, den_q}) begin
          rem_q <= rem_t - {1'b0, den_q};
          quo_q <= {quo_q[DVD_W-2:0], 1'b1};
        end else begin
          rem_q <= rem_t;
          quo_q <= {quo_q[DVD_W-2:0], 1'b0};
        end
        dvd_q <= dvd_q << 1;
        it_q  <= it_q + ITER_W'(1);
      end
      ST_INS: begin
        s_q <= s_q + CNT_W'(1);
        if (ins_ok) begin
          for (int j = 0; j < MAX_TOPK; j++) begin
            if (!ge[j]) begin
              if (j == 0 || ge[(j == 0) ? 0 : j-1]) begin
                bscore_q[j] <= sc;
                bslot_q[j]  <= s_q[SLOT_W-1:0];
              end else begin
                bscore_q[j] <= bscore_q[(j == 0) ? 0 : j-1];
                bslot_q[j]  <= bslot_q[(j == 0) ? 0 : j-1];
              end
            end
          end
        end
      end
      ST_EMIT: begin
        e_q           <= e_q + RANK_W'(1);
        result_slot_o <= bslot_q[e_q];
        score_o       <= bscore_q[e_q];
        rank_o        <= e_q;
        last_result_o <= (K_W'(e_q) == cnt_q - K_W'(1));
        entry_count_o <= vcount_q;
      end
      default: ;
    endcase
  end

endmodule

// File: verif/cts_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cts_checker
// Watches the request, config and result ports of the cosine top-k search,
// keeps its own copy of the store, ranks each query and compares results.
// ----------------------------------------------------------------------------
module cts_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  input  logic                          busy,
  input  logic [1:0]                    cmd_i,
  input  logic [cts_pkg::SLOT_W-1:0]    slot_i,
  input  logic [cts_pkg::ELEM_W-1:0]    elem_i,
  input  logic signed [15:0]            value_i,
  input  logic                          last_i,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [6:0]                    cfg_data_i,
  input  logic                          result_valid_o,
  input  logic [cts_pkg::SLOT_W-1:0]    result_slot_o,
  input  logic signed [15:0]            score_o,
  input  logic [cts_pkg::RANK_W-1:0]    rank_o,
  input  logic                          last_result_o,
  input  logic [cts_pkg::CNT_W-1:0]     entry_count_o,
  output int                            fail_count_o,
  output int                            pending_o
);
  import cts_pkg::*;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic signed [15:0] score;
    logic [RANK_W-1:0]  rank;
    logic               fin;
    logic [CNT_W-1:0]   count;
  } ranked_t;

  ranked_t            ranked_q[$];
  logic signed [15:0] vec_mem[ENTRIES*DIM];
  logic signed [15:0] qbuf[DIM];
  logic [ENTRIES-1:0] live;
  int                 live_cnt;
  logic [6:0]         dims;
  logic [4:0]         topk;

  assign pending_o = ranked_q.size();

  function automatic longint unsigned floor_sqrt(longint unsigned x);
    longint unsigned r, t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= x) r = t;
    end
    return r;
  endfunction

  function automatic logic signed [15:0] cosine(int s, int n);
    longint          dot, qv, sv;
    longint unsigned na, nb, den, mag, quo;
    dot = 0; na = 0; nb = 0;
    for (int i = 0; i < n; i++) begin
      qv = qbuf[i];
      sv = vec_mem[s*DIM + i];
      dot += qv * sv;
      na += qv * qv;
      nb += sv * sv;
    end
    if (na == 0 || nb == 0) return 16'sd0;
    den = floor_sqrt(na) * floor_sqrt(nb);
    mag = (dot < 0) ? -dot : dot;
    quo = (mag * 32768) / den;
    if (dot >= 0) return (quo > 32767) ? 16'sd32767 : 16'(quo);
    return (quo > 32768) ? -16'sd32768 : -16'(quo);
  endfunction

  task automatic rank_query();
    int                 n, k, best;
    logic signed [15:0] sc[ENTRIES];
    logic [ENTRIES-1:0] taken;
    int                 order[$];
    ranked_t            r;
    n = (dims == 0) ? 1 : ((dims > DIM) ? DIM : dims);
    k = (topk > MAX_TOPK) ? MAX_TOPK : topk;
    taken = '0;
    for (int s = 0; s < ENTRIES; s++)
      sc[s] = live[s] ? cosine(s, n) : 16'sd0;
    // strict compare keeps the lower slot ahead on ties
    for (int i = 0; i < k; i++) begin
      best = -1;
      for (int s = 0; s < ENTRIES; s++)
        if (live[s] && !taken[s] && (best < 0 || sc[s] > sc[best])) best = s;
      if (best < 0) break;
      taken[best] = 1'b1;
      order = {order, best};
    end
    foreach (order[i]) begin
      r.slot  = SLOT_W'(order[i]);
      r.score = sc[order[i]];
      r.rank  = RANK_W'(i);
      r.fin   = (i == order.size() - 1);
      r.count = CNT_W'(live_cnt);
      ranked_q = {ranked_q, r};
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    ranked_t e;
    if (!rst_ni) begin
      live = '0;
      live_cnt = 0;
      dims = 7'd64;
      topk = 5'd8;
      fail_count_o = 0;
      ranked_q.delete();
    end else begin
      if (result_valid_o) begin
        if (ranked_q.size() == 0) begin
          $error("result with none expected: slot %0d score %0d", result_slot_o, score_o);
          fail_count_o++;
        end else begin
          e = ranked_q.pop_front();
          if (result_slot_o !== e.slot) begin
            $error("result_slot: expected %0d, actual %0d", e.slot, result_slot_o);
            fail_count_o++;
          end
          if (score_o !== e.score) begin
            $error("score: expected %0d, actual %0d", e.score, score_o);
            fail_count_o++;
          end
          if (rank_o !== e.rank) begin
            $error("rank: expected %0d, actual %0d", e.rank, rank_o);
            fail_count_o++;
          end
          if (last_result_o !== e.fin) begin
            $error("last_result: expected %0d, actual %0d", e.fin, last_result_o);
            fail_count_o++;
          end
          if (entry_count_o !== e.count) begin
            $error("entry_count: expected %0d, actual %0d", e.count, entry_count_o);
            fail_count_o++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_e'(cfg_idx_i))
          CFG_DIMS: dims = cfg_data_i;
          CFG_TOPK: topk = cfg_data_i[4:0];
        endcase
      end
      if (start && !busy) begin
        case (cmd_e'(cmd_i))
          CMD_WRITE: begin
            vec_mem[slot_i*DIM + elem_i] = value_i;
            if (last_i && !live[slot_i]) begin
              live[slot_i] = 1'b1;
              live_cnt++;
            end
          end
          CMD_REMOVE: begin
            if (live[slot_i]) begin
              live[slot_i] = 1'b0;
              live_cnt--;
            end
          end
          CMD_QUERY: begin
            qbuf[elem_i] = value_i;
            if (last_i) rank_query();
          end
          default: ;
        endcase
      end
    end
  end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives store, remove and query requests plus config writes into the
// cosine top-k search; the checker ranks each query and compares results.
// ----------------------------------------------------------------------------
module testbench;
  import cts_pkg::*;

  localparam int STALL_LIMIT = 200000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         cmd_i = CMD_NONE;
  logic [SLOT_W-1:0]  slot_i = '0;
  logic [ELEM_W-1:0]  elem_i = '0;
  logic signed [15:0] value_i = '0;
  logic               last_i = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic               cfg_idx_i = CFG_DIMS;
  logic [6:0]         cfg_data_i = '0;
  logic               result_valid_o;
  logic [SLOT_W-1:0]  result_slot_o;
  logic signed [15:0] score_o;
  logic [RANK_W-1:0]  rank_o;
  logic               last_result_o;
  logic [CNT_W-1:0]   entry_count_o;
  int                 fail_count, pending;

  cosine_topk_search uut (.*);

  cts_checker chk (.*, .fail_count_o(fail_count), .pending_o(pending));

  always #4 clk_i = ~clk_i;

  // stimulus-side bookkeeping: which slots are valid and which elements are set
  logic [ENTRIES-1:0] shadow_live = '0;
  logic [DIM-1:0]     written[ENTRIES];
  int                 dims_n = 64;
  int                 items = 0;
  bit                 idle_on = 1'b1;
  int                 stall = 0;

  // per phase: dims_in_use, top_k and random request budget
  int                 dl[7] = '{2, 0, 5, 127, 8, 3, 1};
  int                 kl[7] = '{16, 31, 3, 1, 0, 8, 16};
  int                 bl[7] = '{8, 8, 8, 1, 8, 8, 8};

  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o) stall <= 0;
    else stall <= stall + 1;
    if (stall >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(7))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return 16'sd0;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic request(cmd_e c, int s, int e, logic signed [15:0] v, bit l);
    if (idle_on && $urandom_range(99) < 25) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    cmd_i   <= c;
    slot_i  <= SLOT_W'(s);
    elem_i  <= ELEM_W'(e);
    value_i <= v;
    last_i  <= l;
    start   <= 1'b1;
    do @(posedge clk_i); while (busy);
    items++;
    if (c == CMD_WRITE) begin
      written[s][e] = 1'b1;
      if (l) shadow_live[s] = 1'b1;
    end else if (c == CMD_REMOVE) begin
      shadow_live[s] = 1'b0;
    end
  endtask

  task automatic store_vec(int s, bit zero);
    for (int e = 0; e < dims_n; e++)
      request(CMD_WRITE, s, e, zero ? 16'sd0 : pick_value(), e == dims_n - 1);
  endtask

  // slots with unset elements in the used range are removed before searching
  task automatic query_vec();
    logic [DIM-1:0] need;
    need = (dims_n == DIM) ? '1 : ((64'd1 << dims_n) - 1);
    for (int s = 0; s < ENTRIES; s++)
      if (shadow_live[s] && ((written[s] & need) != need))
        request(CMD_REMOVE, s, $urandom_range(63), 16'($urandom),
                1'($urandom_range(1)));
    for (int e = 0; e < dims_n; e++)
      request(CMD_QUERY, $urandom_range(63), e, pick_value(), e == dims_n - 1);
  endtask

  task automatic settle();
    start <= 1'b0;
    repeat (4) @(posedge clk_i);
    while (pending != 0 || busy) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic set_cfg(int d, int k);
    settle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_DIMS;
    cfg_data_i <= 7'(d);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_TOPK;
    cfg_data_i <= 7'(k);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    dims_n = (d == 0) ? 1 : ((d > DIM) ? DIM : d);
  endtask

  task automatic random_ops(int budget);
    int r, goal;
    goal = items + budget;
    while (items < goal) begin
      r = $urandom_range(99);
      if (r < 40) store_vec($urandom_range(63), r < 4);
      else if (r < 52) request(CMD_REMOVE, $urandom_range(63), $urandom_range(63),
                               16'($urandom), 1'($urandom_range(1)));
      else if (r < 70) query_vec();
      else if (r < 80) request(CMD_WRITE, $urandom_range(63), $urandom_range(63),
                               pick_value(), 1'($urandom_range(1)));
      else if (r < 88) request(CMD_NONE, $urandom_range(63), $urandom_range(63),
                               16'($urandom), 1'($urandom_range(1)));
      else request(CMD_QUERY, $urandom_range(63), $urandom_range(63), pick_value(), 1'b0);
    end
  endtask

  initial begin
    foreach (written[s]) written[s] = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: full-scale and zero vectors, rewrite, empty remove, unused cmd
    set_cfg(2, 16);
    request(CMD_WRITE, 0, 0, 16'sd32767, 1'b0);
    request(CMD_WRITE, 0, 1, 16'sd32767, 1'b1);
    request(CMD_WRITE, 63, 0, -16'sd32768, 1'b0);
    request(CMD_WRITE, 63, 1, -16'sd32768, 1'b1);
    request(CMD_WRITE, 1, 0, 16'sd0, 1'b0);
    request(CMD_WRITE, 1, 1, 16'sd0, 1'b1);
    request(CMD_WRITE, 2, 0, 16'sd32767, 1'b0);
    request(CMD_WRITE, 2, 1, -16'sd32768, 1'b1);
    request(CMD_REMOVE, 40, 0, 16'sd0, 1'b0);
    request(CMD_NONE, 63, 63, -16'sd1, 1'b1);
    request(CMD_QUERY, 0, 0, 16'sd32767, 1'b0);
    request(CMD_QUERY, 0, 1, 16'sd32767, 1'b1);
    request(CMD_WRITE, 0, 0, 16'sd0, 1'b0);
    request(CMD_WRITE, 0, 1, 16'sd1, 1'b1);
    request(CMD_REMOVE, 2, 63, 16'sd0, 1'b1);
    request(CMD_QUERY, 0, 0, 16'sd0, 1'b0);
    request(CMD_QUERY, 0, 1, 16'sd0, 1'b1);
    request(CMD_QUERY, 63, 0, -16'sd32768, 1'b0);
    request(CMD_QUERY, 63, 1, 16'sd5, 1'b1);

    foreach (dl[p]) begin
      set_cfg(dl[p], kl[p]);
      idle_on = (p != 3);
      random_ops(bl[p]);
      query_vec();
    end
    idle_on = 1'b1;

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
